/* hw/rtl/edf_dispatch_decision_top_defines.svh */
// ----------------------------------------------------------------------------
// EDF dispatch decision assertion macros
// Shared concurrent assertion forms used by the checker of the dispatch block.
// ----------------------------------------------------------------------------
`ifndef EDF_DISPATCH_DECISION_TOP_DEFINES_SVH
`define EDF_DISPATCH_DECISION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDD_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/edd_pkg.sv */
// ----------------------------------------------------------------------------
// EDF dispatch decision package
// Widths, codes and the queue entry type shared by the dispatch block.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned ID_BITS        = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;

  localparam logic [1:0] FUNC_READY   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_DECIDE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_READY,
    KIND_RELEASE,
    KIND_DECIDE
  } kind_e;

  typedef enum logic [1:0] {
    OUTCOME_RUN   = 2'd0,
    OUTCOME_MISS  = 2'd1,
    OUTCOME_IDLE  = 2'd2,
    OUTCOME_EMPTY = 2'd3
  } outcome_e;

  // For a ready entry time_a is the deadline and time_b the remaining time.
  // For a release entry time_a is the release time and time_b the period.
  typedef struct packed {
    kind_e kind;
    logic  missed;
    id_t   id;
    time_t now;
    time_t time_a;
    time_t time_b;
  } entry_t;

endpackage

/* hw/rtl/edd_front.sv */
// ----------------------------------------------------------------------------
// EDF dispatch decision front end
// Accepts requests, classifies them, flags missed deadlines and queues them.
// ----------------------------------------------------------------------------
module edd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     now_i,
  input  logic [edd_pkg::ID_BITS-1:0]       entry_id_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     deadline_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     remaining_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     release_time_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     period_i,
  output logic                              q_valid_o,
  output edd_pkg::entry_t                   q_entry_o,
  input  logic                              q_pop_i
);

  edd_pkg::entry_t                          mem_q [edd_pkg::QUEUE_DEPTH];
  logic [edd_pkg::QUEUE_IDX_BITS-1:0]       wr_ptr_q, wr_ptr_d;
  logic [edd_pkg::QUEUE_IDX_BITS-1:0]       rd_ptr_q, rd_ptr_d;
  logic [edd_pkg::QUEUE_CNT_BITS-1:0]       count_q, count_d;
  edd_pkg::entry_t                          entry_d;
  logic                                     func_ok;
  logic                                     push;

  always_comb begin
    entry_d        = '0;
    entry_d.id     = entry_id_i;
    entry_d.now    = now_i;
    entry_d.missed = (now_i > deadline_i) || ((now_i == deadline_i) && (remaining_i != '0));
    func_ok        = 1'b1;
    unique case (func_i)
      edd_pkg::FUNC_READY: begin
        entry_d.kind   = edd_pkg::KIND_READY;
        entry_d.time_a = deadline_i;
        entry_d.time_b = remaining_i;
      end
      edd_pkg::FUNC_RELEASE: begin
        entry_d.kind   = edd_pkg::KIND_RELEASE;
        entry_d.time_a = release_time_i;
        entry_d.time_b = period_i;
      end
      edd_pkg::FUNC_DECIDE: begin
        entry_d.kind = edd_pkg::KIND_DECIDE;
      end
      default: begin
        entry_d.kind = edd_pkg::KIND_DECIDE;
        func_ok      = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (count_q != edd_pkg::QUEUE_CNT_BITS'(edd_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o && func_ok;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      if (wr_ptr_q == edd_pkg::QUEUE_IDX_BITS'(edd_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (q_pop_i) begin
      if (rd_ptr_q == edd_pkg::QUEUE_IDX_BITS'(edd_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    unique case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

endmodule

/* hw/rtl/edd_back.sv */
// ----------------------------------------------------------------------------
// EDF dispatch decision back end
// Keeps the running minima and forms the dispatch result on a decide request.
// ----------------------------------------------------------------------------
module edd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  edd_pkg::entry_t                   q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        outcome_o,
  output logic [edd_pkg::ID_BITS-1:0]       thread_id_o,
  output logic [edd_pkg::TIME_BITS-1:0]     grant_time_o
);

  logic              best_valid_q, best_valid_d;
  edd_pkg::id_t      best_id_q;
  edd_pkg::time_t    best_dl_q;
  edd_pkg::time_t    best_rem_q;
  logic              miss_valid_q, miss_valid_d;
  edd_pkg::id_t      miss_id_q;
  logic              next_valid_q, next_valid_d;
  edd_pkg::time_t    next_rel_q;
  logic              pre_valid_q, pre_valid_d;
  edd_pkg::time_t    pre_rel_q;
  logic              out_valid_q, out_valid_d;
  edd_pkg::outcome_e outcome_q, outcome_d;
  edd_pkg::id_t      tid_q, tid_d;
  edd_pkg::time_t    time_q, time_d;

  logic              take_ready, take_release, take_decide;
  logic              best_upd, miss_upd, next_upd, pre_upd;
  edd_pkg::id_t      next_id_q;
  edd_pkg::id_t      pre_id_q;
  edd_pkg::time_t    lim_dl, lim_pre, lim_next, run_time;

  assign q_pop_o = q_valid_i &&
                   ((q_entry_i.kind != edd_pkg::KIND_DECIDE) || !out_valid_q || out_ready_i);

  assign take_ready   = q_pop_o && (q_entry_i.kind == edd_pkg::KIND_READY);
  assign take_release = q_pop_o && (q_entry_i.kind == edd_pkg::KIND_RELEASE);
  assign take_decide  = q_pop_o && (q_entry_i.kind == edd_pkg::KIND_DECIDE);

  assign best_upd = take_ready &&
                    (!best_valid_q || (q_entry_i.time_a < best_dl_q) ||
                     ((q_entry_i.time_a == best_dl_q) && (q_entry_i.id < best_id_q)));
  assign miss_upd = take_ready && q_entry_i.missed &&
                    (!miss_valid_q || (q_entry_i.id < miss_id_q));
  assign next_upd = take_release &&
                    (!next_valid_q || (q_entry_i.time_a < next_rel_q) ||
                     ((q_entry_i.time_a == next_rel_q) && (q_entry_i.id < next_id_q)));

  // The release preempts when release plus period lands before the best deadline.
  assign pre_upd = take_release && best_valid_q && (q_entry_i.time_a < best_dl_q) &&
                   (q_entry_i.time_b < (best_dl_q - q_entry_i.time_a)) &&
                   (!pre_valid_q || (q_entry_i.time_a < pre_rel_q) ||
                    ((q_entry_i.time_a == pre_rel_q) && (q_entry_i.id < pre_id_q)));

  always_comb begin
    best_valid_d = take_decide ? 1'b0 : (best_valid_q || best_upd);
    miss_valid_d = take_decide ? 1'b0 : (miss_valid_q || miss_upd);
    next_valid_d = take_decide ? 1'b0 : (next_valid_q || next_upd);
    pre_valid_d  = take_decide ? 1'b0 : (pre_valid_q || pre_upd);
  end

  always_comb begin
    lim_dl   = (best_dl_q > q_entry_i.now) ? (best_dl_q - q_entry_i.now) : '0;
    lim_pre  = (pre_rel_q > q_entry_i.now) ? (pre_rel_q - q_entry_i.now) : '0;
    lim_next = (next_rel_q > q_entry_i.now) ? (next_rel_q - q_entry_i.now) : '0;
    run_time = (best_rem_q < lim_dl) ? best_rem_q : lim_dl;
    if (pre_valid_q && (lim_pre < run_time)) begin
      run_time = lim_pre;
    end
    priority if (miss_valid_q) begin
      outcome_d = edd_pkg::OUTCOME_MISS;
      tid_d     = miss_id_q;
      time_d    = '0;
    end else if (best_valid_q) begin
      outcome_d = edd_pkg::OUTCOME_RUN;
      tid_d     = best_id_q;
      time_d    = run_time;
    end else if (next_valid_q) begin
      outcome_d = edd_pkg::OUTCOME_IDLE;
      tid_d     = '0;
      time_d    = lim_next;
    end else begin
      outcome_d = edd_pkg::OUTCOME_EMPTY;
      tid_d     = '0;
      time_d    = '0;
    end
  end

  always_comb begin
    if (take_decide) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      miss_valid_q <= 1'b0;
      next_valid_q <= 1'b0;
      pre_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      best_valid_q <= best_valid_d;
      miss_valid_q <= miss_valid_d;
      next_valid_q <= next_valid_d;
      pre_valid_q  <= pre_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_upd) begin
      best_id_q  <= q_entry_i.id;
      best_dl_q  <= q_entry_i.time_a;
      best_rem_q <= q_entry_i.time_b;
    end
    if (miss_upd) begin
      miss_id_q <= q_entry_i.id;
    end
    if (next_upd) begin
      next_rel_q <= q_entry_i.time_a;
      next_id_q  <= q_entry_i.id;
    end
    if (pre_upd) begin
      pre_rel_q <= q_entry_i.time_a;
      pre_id_q  <= q_entry_i.id;
    end
    if (take_decide) begin
      outcome_q <= outcome_d;
      tid_q     <= tid_d;
      time_q    <= time_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign outcome_o    = outcome_q;
  assign thread_id_o  = tid_q;
  assign grant_time_o = time_q;

endmodule

/* hw/rtl/edf_dispatch_decision_top.sv */
// ----------------------------------------------------------------------------
// EDF dispatch decision top level
// Earliest-deadline-first dispatch decision over streamed queue entries.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its queue has room:
// ready-thread entries, then release entries, then a decide request that
// returns one result and clears the running state. Each entry updates the
// running minima in the back end, which sets the sustained rate of one
// request per cycle unless a waiting result stalls it. A two-entry queue
// separates the front end from the back end; a decide result passes through
// the queue memory and the back-end result register to the output. A request
// with an unused function code is accepted and has no effect. Only a waiting
// untaken result stalls the back end; input is taken until the queue fills.
module edf_dispatch_decision_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     now_i,
  input  logic [edd_pkg::ID_BITS-1:0]       entry_id_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     deadline_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     remaining_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     release_time_i,
  input  logic [edd_pkg::TIME_BITS-1:0]     period_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        outcome_o,
  output logic [edd_pkg::ID_BITS-1:0]       thread_id_o,
  output logic [edd_pkg::TIME_BITS-1:0]     grant_time_o
);

  logic            q_valid;
  logic            q_pop;
  edd_pkg::entry_t q_entry;

  edd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .now_i          (now_i),
    .entry_id_i     (entry_id_i),
    .deadline_i     (deadline_i),
    .remaining_i    (remaining_i),
    .release_time_i (release_time_i),
    .period_i       (period_i),
    .q_valid_o      (q_valid),
    .q_entry_o      (q_entry),
    .q_pop_i        (q_pop)
  );

  edd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .outcome_o    (outcome_o),
    .thread_id_o  (thread_id_o),
    .grant_time_o (grant_time_o)
  );

endmodule

/* hw/rtl/edd_checker.sv */
// ----------------------------------------------------------------------------
// EDF dispatch decision checker
// Port-level assertions on the dispatch block, bound to its top level.
// ----------------------------------------------------------------------------
`include "edf_dispatch_decision_top_defines.svh"

module edd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [1:0]                        outcome_o,
  input  logic [edd_pkg::ID_BITS-1:0]       thread_id_o,
  input  logic [edd_pkg::TIME_BITS-1:0]     grant_time_o
);

  `EDD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(outcome_o) && $stable(thread_id_o) && $stable(grant_time_o), "Stalled result changed.")

  `EDD_ASSERT_SAME(a_no_id_when_idle, out_valid_o && (outcome_o == edd_pkg::OUTCOME_IDLE || outcome_o == edd_pkg::OUTCOME_EMPTY), thread_id_o == '0, "Idle or empty result carries a thread id.")

  `EDD_ASSERT_SAME(a_no_time_on_miss, out_valid_o && (outcome_o == edd_pkg::OUTCOME_MISS || outcome_o == edd_pkg::OUTCOME_EMPTY), grant_time_o == '0, "Miss or empty result grants time.")

endmodule

bind edf_dispatch_decision_top edd_checker u_edd_checker (.*);
